>>> rtl/core/mspg_pkg.sv
// ----------------------------------------------------------------------------
// mspg_pkg
// Shared types, constants and helpers of the smoothstep glow block.
// ----------------------------------------------------------------------------
package mspg_pkg;

	localparam int HALF_WIDTH  = 64;
	localparam int HALF_HEIGHT = 32;

	localparam int DDA_W = 40;
	localparam int COL_W = (HALF_WIDTH  > 2) ? $clog2(HALF_WIDTH)  : 1;
	localparam int ROW_W = (HALF_HEIGHT > 2) ? $clog2(HALF_HEIGHT) : 1;
	localparam int PIX_W = 24;
	localparam int LVL_W = 8;

	localparam logic [LVL_W-1:0] PEAK_RESET = LVL_W'(50);
	localparam logic [LVL_W-1:0] LVL_MAX    = LVL_W'(255);

	localparam logic signed [DDA_W-1:0] CUBE_W      =
		DDA_W'(HALF_WIDTH * HALF_WIDTH * HALF_WIDTH);
	localparam logic signed [DDA_W-1:0] CUBE_H      =
		DDA_W'(HALF_HEIGHT * HALF_HEIGHT * HALF_HEIGHT);
	localparam logic signed [DDA_W-1:0] HALF_CUBE_W =
		DDA_W'(HALF_WIDTH * HALF_WIDTH * HALF_WIDTH / 2);
	localparam logic signed [DDA_W-1:0] HALF_CUBE_H =
		DDA_W'(HALF_HEIGHT * HALF_HEIGHT * HALF_HEIGHT / 2);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARM,
		ST_HNORM,
		ST_VNORM,
		ST_OUT
	} glow_state_t;

	typedef struct packed {
		logic in_load;
		logic arm;
		logic h_sub;
		logic h_step;
		logic v_sub;
		logic v_step;
		logic out_load;
	} glow_cmd_t;

	typedef struct packed {
		logic h_over;
		logic v_over;
		logic col_last;
		logic out_free;
	} glow_stat_t;

	typedef struct packed {
		logic signed [DDA_W-1:0] d1;
		logic signed [DDA_W-1:0] d2;
		logic signed [DDA_W-1:0] d3;
	} dda_deltas_t;

	// a = -2L, b = 3*L*half; d1 = a+b, d2 = 6a+2b, d3 = 6a
	function automatic dda_deltas_t arm_deltas(input logic [LVL_W-1:0] lvl, input int half);
		logic signed [DDA_W-1:0] lv;
		logic signed [DDA_W-1:0] a;
		logic signed [DDA_W-1:0] b;
		dda_deltas_t r;
		lv   = signed'(DDA_W'(lvl));
		a    = -(lv <<< 1);
		b    = lv * signed'(DDA_W'(3 * half));
		r.d1 = a + b;
		r.d2 = (a <<< 2) + (a <<< 1) + (b <<< 1);
		r.d3 = (a <<< 2) + (a <<< 1);
		return r;
	endfunction

	function automatic logic [7:0] blend_ch(input logic [7:0] c, input logic [LVL_W-1:0] lvl);
		logic [15:0] prod;
		prod = 16'(LVL_MAX - c) * 16'(lvl);
		return 8'(c + prod[15:8]);
	endfunction

	function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] px,
			input logic [LVL_W-1:0] lvl);
		return {px[23:16], blend_ch(px[15:8], lvl), blend_ch(px[7:0], lvl)};
	endfunction

endpackage

>>> rtl/core/mspg_ctrl.sv
// ----------------------------------------------------------------------------
// mspg_ctrl
// Sequencer: load, arm and blend, column DDA normalize/step, row DDA
// normalize/step, hand result to the output register.
// ----------------------------------------------------------------------------
module mspg_ctrl
	import mspg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  glow_stat_t stat,
	output glow_cmd_t  cmd
);

	glow_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_ARM;
			end
			ST_ARM: begin
				state_nx = ST_HNORM;
			end
			ST_HNORM: begin
				if (!stat.h_over) state_nx = stat.col_last ? ST_VNORM : ST_OUT;
			end
			ST_VNORM: begin
				if (!stat.v_over) state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			ST_ARM: begin
				cmd.arm = 1'b1;
			end
			ST_HNORM: begin
				cmd.h_sub  = stat.h_over;
				cmd.h_step = !stat.h_over;
			end
			ST_VNORM: begin
				cmd.v_sub  = stat.v_over;
				cmd.v_step = !stat.v_over;
			end
			ST_OUT: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/core/mspg_dp.sv
// ----------------------------------------------------------------------------
// mspg_dp
// Datapath: peak register, row and column DDAs, pixel blend, output register.
// ----------------------------------------------------------------------------
module mspg_dp
	import mspg_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [LVL_W-1:0]     cfg_peak,
	input  logic                 in_start,
	input  logic [4*PIX_W-1:0]   in_pixels,
	input  glow_cmd_t            cmd,
	output glow_stat_t           stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [4*PIX_W-1:0]   out_pixels,
	output logic                 out_last
);

	logic [LVL_W-1:0]        peak_q;
	logic [4*PIX_W-1:0]      pix_q;
	logic [4*PIX_W-1:0]      res_q;
	logic                    done_q;

	logic [LVL_W-1:0]        row_level_q, col_level_q;
	logic signed [DDA_W-1:0] row_err_q, row_d1_q, row_d2_q, row_d3_q;
	logic signed [DDA_W-1:0] col_err_q, col_d1_q, col_d2_q, col_d3_q;
	logic [COL_W-1:0]        col_cnt_q;
	logic [ROW_W-1:0]        row_cnt_q;

	logic                    out_valid_q;
	logic [4*PIX_W-1:0]      out_pix_q;
	logic                    out_last_q;

	logic                    arm_v, arm_h, row_last;
	logic [LVL_W-1:0]        lvl_eff, h_seed;
	dda_deltas_t             v_arm, h_arm, v_rst;

	assign arm_v    = (row_cnt_q == '0) && (col_cnt_q == '0);
	assign arm_h    = (col_cnt_q == '0);
	assign h_seed   = arm_v ? '0 : row_level_q;
	assign lvl_eff  = arm_h ? '0 : col_level_q;
	assign v_arm    = arm_deltas(peak_q, HALF_HEIGHT);
	assign h_arm    = arm_deltas(h_seed, HALF_WIDTH);
	assign v_rst    = arm_deltas(PEAK_RESET, HALF_HEIGHT);
	assign row_last = (row_cnt_q == ROW_W'(HALF_HEIGHT - 1));

	assign stat.h_over   = col_err_q > HALF_CUBE_W;
	assign stat.v_over   = row_err_q > HALF_CUBE_H;
	assign stat.col_last = (col_cnt_q == COL_W'(HALF_WIDTH - 1));
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_pixels = out_pix_q;
	assign out_last   = out_last_q;

	// pixel and result holding, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.in_load) pix_q <= in_pixels;
		if (cmd.arm) begin
			for (int k = 0; k < 4; k++) begin
				res_q[k*PIX_W +: PIX_W] <= blend_px(pix_q[k*PIX_W +: PIX_W], lvl_eff);
			end
		end
		if (cmd.out_load) begin
			out_pix_q  <= res_q;
			out_last_q <= done_q;
		end
		if (cmd.h_step) done_q <= 1'b0;
		if (cmd.v_step) done_q <= row_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q      <= PEAK_RESET;
			row_level_q <= '0;
			row_err_q   <= '0;
			row_d1_q    <= v_rst.d1;
			row_d2_q    <= v_rst.d2;
			row_d3_q    <= v_rst.d3;
			col_level_q <= '0;
			col_err_q   <= '0;
			col_d1_q    <= '0;
			col_d2_q    <= '0;
			col_d3_q    <= '0;
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) peak_q <= cfg_peak;

			if (cmd.in_load && in_start) begin
				col_cnt_q <= '0;
				row_cnt_q <= '0;
			end

			if (cmd.arm) begin
				if (arm_v) begin
					row_level_q <= '0;
					row_err_q   <= '0;
					row_d1_q    <= v_arm.d1;
					row_d2_q    <= v_arm.d2;
					row_d3_q    <= v_arm.d3;
				end
				if (arm_h) begin
					col_level_q <= '0;
					col_err_q   <= '0;
					col_d1_q    <= h_arm.d1;
					col_d2_q    <= h_arm.d2;
					col_d3_q    <= h_arm.d3;
				end
			end

			if (cmd.h_sub) begin
				if (col_level_q != LVL_MAX) col_level_q <= col_level_q + 1'b1;
				col_err_q <= col_err_q - CUBE_W;
			end
			if (cmd.h_step) begin
				col_err_q <= col_err_q + col_d1_q;
				col_d1_q  <= col_d1_q + col_d2_q;
				col_d2_q  <= col_d2_q + col_d3_q;
				col_cnt_q <= stat.col_last ? '0 : col_cnt_q + 1'b1;
			end

			if (cmd.v_sub) begin
				if (row_level_q != LVL_MAX) row_level_q <= row_level_q + 1'b1;
				row_err_q <= row_err_q - CUBE_H;
			end
			if (cmd.v_step) begin
				row_err_q <= row_err_q + row_d1_q;
				row_d1_q  <= row_d1_q + row_d2_q;
				row_d2_q  <= row_d2_q + row_d3_q;
				row_cnt_q <= row_last ? '0 : row_cnt_q + 1'b1;
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/mirrored_smoothstep_pixel_glow.sv
// ----------------------------------------------------------------------------
// mirrored_smoothstep_pixel_glow
// Smoothstep glow blend of mirrored RGB888 pixel quads toward white.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per pixel quad, rows edge-to-center, columns
//   edge-to-center within a row. tuser = frame_start re-arms both DDAs.
//   m_axis returns one blended quad per input item, in order; tlast marks
//   the last quad of the rectangle (HALF_WIDTH x HALF_HEIGHT quads).
//   cfg_* writes peak_level; cfg_ready is always high. The new peak is used
//   from the next rectangle start on.
// Sequence:
//   IDLE (accept), ARM+blend, column step, output load for each item, plus
//   one column error subtract per span before the column step, plus on the
//   last column of a row one row error subtract per span and a row step
//   (also once the level sits at 255). Each DDA normalizes by subtracting a
//   single span at a time. A new item is taken only after the previous
//   result is in the output register.
// Reset: row DDA comes up armed for peak 50, column DDA cleared, output empty, ready for an item.
// Stall: the result waits in the output register; the next item is taken
//   and worked on, then waits in the output load state until m_axis drains.
// ----------------------------------------------------------------------------
module mirrored_smoothstep_pixel_glow
	import mspg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration: peak_level
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LVL_W-1:0]   cfg_data,
	// input items
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// [23:0] pixel_top_left, [47:24] pixel_top_right,
	// [71:48] pixel_bottom_left, [95:72] pixel_bottom_right
	input  logic [4*PIX_W-1:0] s_axis_tdata,
	// [0] frame_start
	input  logic               s_axis_tuser,
	// result items
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// [23:0] glow_top_left, [47:24] glow_top_right,
	// [71:48] glow_bottom_left, [95:72] glow_bottom_right
	output logic [4*PIX_W-1:0] m_axis_tdata,
	// frame_done
	output logic               m_axis_tlast
);

	glow_cmd_t  cmd;
	glow_stat_t stat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	mspg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mspg_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid),
		.cfg_peak   (cfg_data),
		.in_start   (s_axis_tuser),
		.in_pixels  (s_axis_tdata),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_pixels (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

endmodule

>>> rtl/core/mspg_checker.sv
// ----------------------------------------------------------------------------
// mspg_checker
// Port-level checks of the glow block, bound to the top level.
// ----------------------------------------------------------------------------
module mspg_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// one item at a time: no accept in the cycle after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken back to back");

	// a result cannot appear right after its item was taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
		else $error("result too early");

	// a new result is loaded only while the input side is closed
	a_load_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result loaded while accepting");

endmodule

bind mirrored_smoothstep_pixel_glow mspg_checker u_mspg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the mirrored smoothstep glow blend.
// Drives pixel quads in edge-to-center order and writes peak levels between
// phases. A local model of both smoothstep DDAs predicts every blended quad
// and the end-of-rectangle flag, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb;
	import mspg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// error terms are compared against half of the cube of the span
	localparam logic signed [DDA_W-1:0] COL_SPAN = DDA_W'(HALF_WIDTH * HALF_WIDTH * HALF_WIDTH);
	localparam logic signed [DDA_W-1:0] ROW_SPAN =
		DDA_W'(HALF_HEIGHT * HALF_HEIGHT * HALF_HEIGHT);
	localparam int QUAD_W     = 4 * PIX_W;
	localparam int RECT_ITEMS = HALF_WIDTH * HALF_HEIGHT;

	// one cubic forward-difference DDA: current level, error and its deltas
	typedef struct {
		logic [LVL_W-1:0]        level;
		logic signed [DDA_W-1:0] err;
		logic signed [DDA_W-1:0] d1;
		logic signed [DDA_W-1:0] d2;
		logic signed [DDA_W-1:0] d3;
	} smoothstep_dda_t;

	typedef struct {
		logic [QUAD_W-1:0] quad;
		logic              done;
	} glow_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LVL_W-1:0]  cfg_data;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	// [23:0] pixel_top_left, [47:24] pixel_top_right,
	// [71:48] pixel_bottom_left, [95:72] pixel_bottom_right
	logic [QUAD_W-1:0] s_axis_tdata;
	// [0] frame_start
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// [23:0] glow_top_left, [47:24] glow_top_right,
	// [71:48] glow_bottom_left, [95:72] glow_bottom_right
	logic [QUAD_W-1:0] m_axis_tdata;
	// [0] frame_done
	logic              m_axis_tlast;

	// predictor state: register copy, both DDAs and the scan position
	logic [LVL_W-1:0] peak_shadow;
	smoothstep_dda_t  row_dda;
	smoothstep_dda_t  col_dda;
	int unsigned      col_pos;
	int unsigned      row_pos;

	glow_result_t glow_expected[$];
	int unsigned  mismatches;
	bit           gaps_on;

	mirrored_smoothstep_pixel_glow u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// generous cap on the run time of a few thousand items
	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// a = -2L, b = 3*L*half; first delta a+b, second 6a+2b, third 6a
	function automatic smoothstep_dda_t dda_arm(input logic [LVL_W-1:0] target,
			input int half);
		logic signed [DDA_W-1:0] t;
		logic signed [DDA_W-1:0] a;
		logic signed [DDA_W-1:0] b;
		smoothstep_dda_t         r;
		t       = DDA_W'(target);
		a       = -2 * t;
		b       = 3 * half * t;
		r.level = '0;
		r.err   = '0;
		r.d1    = a + b;
		r.d2    = 6 * a + 2 * b;
		r.d3    = 6 * a;
		return r;
	endfunction

	// normalize the error one span at a time, level saturating at full scale,
	// then advance the forward differences
	function automatic void dda_advance(inout smoothstep_dda_t s,
			input logic signed [DDA_W-1:0] span);
		while (s.err > span / 2) begin
			if (s.level != LVL_MAX)
				s.level++;
			s.err -= span;
		end
		s.err += s.d1;
		s.d1  += s.d2;
		s.d2  += s.d3;
	endfunction

	// c + ((255 - c) * L) >> 8, kept to 8 bits
	function automatic logic [7:0] lift_channel(input logic [7:0] c,
			input logic [LVL_W-1:0] lvl);
		logic [15:0] p;
		p = (16'(8'hff) - 16'(c)) * 16'(lvl);
		return c + p[15:8];
	endfunction

	function automatic glow_result_t glow_predict(input logic frame_start,
			input logic [QUAD_W-1:0] quad);
		glow_result_t     r;
		logic [PIX_W-1:0] px;
		int               k;
		if (frame_start) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (row_pos == 0 && col_pos == 0)
			row_dda = dda_arm(peak_shadow, HALF_HEIGHT);
		if (col_pos == 0)
			col_dda = dda_arm(row_dda.level, HALF_WIDTH);
		for (k = 0; k < 4; k++) begin
			px = quad[k*PIX_W +: PIX_W];
			r.quad[k*PIX_W +: PIX_W] = {px[23:16], lift_channel(px[15:8], col_dda.level),
				lift_channel(px[7:0], col_dda.level)};
		end
		r.done = 1'b0;
		dda_advance(col_dda, COL_SPAN);
		col_pos++;
		if (col_pos >= HALF_WIDTH) begin
			col_pos = 0;
			dda_advance(row_dda, ROW_SPAN);
			row_pos++;
			if (row_pos >= HALF_HEIGHT) begin
				row_pos = 0;
				r.done  = 1'b1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stream drivers
	// ------------------------------------------------------------------------

	// Called and returns at a falling edge. tvalid stays high on return so the
	// next item can follow back to back; release_stream drops it otherwise.
	task automatic send_quad(input logic frame_start, input logic [QUAD_W-1:0] quad);
		if (gaps_on) begin
			while ($urandom_range(99) < 13) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= quad;
		s_axis_tuser  <= frame_start;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		glow_expected.push_back(glow_predict(frame_start, quad));
		@(negedge clk);
	endtask

	task automatic release_stream();
		s_axis_tvalid <= 1'b0;
	endtask

	// peak_level only changes with the block drained
	task automatic write_peak(input logic [LVL_W-1:0] value);
		release_stream();
		while (glow_expected.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		peak_shadow = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly random, now and then black or white to hit channel extremes
	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [QUAD_W-1:0] rand_quad();
		return {rand_pixel(), rand_pixel(), rand_pixel(), rand_pixel()};
	endfunction

	// ------------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------------

	always @(negedge clk)
		m_axis_tready <= !gaps_on || ($urandom_range(99) >= 13);

	always @(posedge clk) begin
		glow_result_t want;
		int           k;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (glow_expected.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, actual %h last %b",
					$realtime, m_axis_tdata, m_axis_tlast);
			end else begin
				want = glow_expected.pop_front();
				for (k = 0; k < 4; k++) begin
					if (m_axis_tdata[k*PIX_W +: PIX_W] !== want.quad[k*PIX_W +: PIX_W]) begin
						mismatches++;
						$display("%0t: glow pixel %0d expected %h actual %h", $realtime, k,
							want.quad[k*PIX_W +: PIX_W], m_axis_tdata[k*PIX_W +: PIX_W]);
					end
				end
				if (m_axis_tlast !== want.done) begin
					mismatches++;
					$display("%0t: frame_done expected %b actual %b", $realtime,
						want.done, m_axis_tlast);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// first row after reset: level is still zero, so quads pass unchanged;
	// covers the field extremes and the implicit rectangle start after reset
	task automatic test_after_reset();
		send_quad(1'b0, {4{24'h000000}});
		send_quad(1'b0, {4{24'hffffff}});
		send_quad(1'b0, {24'h555555, 24'haaaaaa, 24'h555555, 24'haaaaaa});
		send_quad(1'b0, {24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555});
		send_quad(1'b0, {24'h808080, 24'h0000ff, 24'h00ff00, 24'hff0000});
	endtask

	// frame_start re-arms mid-row, also on two items in a row
	task automatic test_frame_start();
		send_quad(1'b1, rand_quad());
		send_quad(1'b0, rand_quad());
		send_quad(1'b1, rand_quad());
		send_quad(1'b1, rand_quad());
	endtask

	// a write inside a rectangle waits for the next rectangle start
	task automatic test_mid_rectangle_write();
		write_peak(8'd0);
		send_quad(1'b0, rand_quad());
		send_quad(1'b0, rand_quad());
		send_quad(1'b0, rand_quad());
		send_quad(1'b1, {4{24'h7f7f7f}});
		send_quad(1'b0, rand_quad());
	endtask

	// whole rectangle at full peak: levels saturate, frame_done on the last
	// quad, and the next quads start a new rectangle without frame_start
	task automatic test_full_rectangle();
		int n;
		write_peak(LVL_MAX);
		gaps_on = 1'b0;
		for (n = 0; n < RECT_ITEMS; n++) begin
			if (n == RECT_ITEMS / 4)
				gaps_on = 1'b1;
			send_quad(n == 0, rand_quad());
		end
		for (n = 0; n < 6; n++)
			send_quad(1'b0, rand_quad());
	endtask

	// partial rectangles over several peaks; one round carries on without a
	// restart, and a stray frame_start now and then breaks a rectangle
	task automatic test_random_restarts();
		int round;
		int n;
		int len;
		logic [LVL_W-1:0] peak;
		for (round = 0; round < 4; round++) begin
			case (round)
				0: peak = LVL_MAX;
				1: peak = '0;
				default: peak = LVL_W'($urandom_range(255));
			endcase
			write_peak(peak);
			len = $urandom_range(3) == 0 ? $urandom_range(8, 20) : $urandom_range(70, 200);
			for (n = 0; n < len; n++)
				send_quad((n == 0 && round != 2) || $urandom_range(49) == 0, rand_quad());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		mismatches    = 0;
		gaps_on       = 1'b1;

		// predictor comes up as the block does: armed for the reset peak
		peak_shadow = PEAK_RESET;
		row_dda     = dda_arm(PEAK_RESET, HALF_HEIGHT);
		col_dda     = dda_arm('0, HALF_WIDTH);
		col_pos     = 0;
		row_pos     = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_frame_start();
		test_mid_rectangle_write();
		test_full_rectangle();
		test_random_restarts();

		release_stream();
		while (glow_expected.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
